// File: hw/rtl/cos_pkg.sv
`timescale 1ns / 1ps

package cos_pkg;

    // Sweep and history geometry
    localparam int NUM_CHANNELS  = 126;
    localparam int SAMPLES       = 16;
    localparam int HISTORY_DEPTH = 128;

    // Field widths
    localparam int CH_W     = 7;
    localparam int HITS_W   = 8;
    localparam int IDX_W    = 8;
    localparam int HEIGHT_W = 6;
    localparam int COL_W    = 7;
    localparam int SCALE_W  = 6;

    // Width of the hits by full-scale product
    localparam int PROD_W = HITS_W + SCALE_W;

    // History addressing; the column is widened so that depths up to 511 compare cleanly
    localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int COL_EXT_W  = 9;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [SCALE_W-1:0]  FULL_SCALE_RESET = 6'd55;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX       = 6'd63;
    localparam logic [HITS_W-1:0]   HITS_MAX         = 8'd255;

    // Request actions
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_PAUSE  = 2'd1,
        ACT_EXIT   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // Result kinds
    localparam logic [1:0] KIND_COUNT   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_HIST    = 2'd2;

    typedef struct packed {
        t_action            action;
        logic               carrier_seen;
        logic [COL_W-1:0]   column;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CH_W-1:0]     channel;
        logic [HITS_W-1:0]   hit_count;
        logic [HEIGHT_W-1:0] bar_height;
        logic                is_last;
    } t_out_item;

    // Control from the sweep logic to the history row
    typedef struct packed {
        logic                push;
        logic [HEIGHT_W-1:0] height;
        logic [COL_W-1:0]    column;
    } t_hist_ctrl;

endpackage

// File: hw/rtl/cos_cell.sv
`timescale 1ns / 1ps

module cos_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [cos_pkg::HEIGHT_W-1:0] i_data,
    output logic [cos_pkg::HEIGHT_W-1:0] o_data
);

    logic [cos_pkg::HEIGHT_W-1:0] r_height;

    // Take the neighbour's height on a push, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
        end else if (i_shift) begin
            r_height <= i_data;
        end
    end

    assign o_data = r_height;

endmodule

// File: hw/rtl/cos_chain.sv
`timescale 1ns / 1ps

module cos_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cos_pkg::t_hist_ctrl          i_ctrl,
    output logic [cos_pkg::HEIGHT_W-1:0] o_rd_height
);

    logic [cos_pkg::HEIGHT_W-1:0]   w_cell [cos_pkg::HISTORY_DEPTH];
    logic [cos_pkg::COL_EXT_W-1:0]  w_col_ext;
    logic                           w_in_range;
    logic [cos_pkg::HIST_IDX_W-1:0] w_idx;

    // Row of cells: cell 0 is the oldest, the newest height enters at the far end
    for (genvar g = 0; g < cos_pkg::HISTORY_DEPTH; g++) begin : g_cell
        logic [cos_pkg::HEIGHT_W-1:0] w_feed;

        if (g == cos_pkg::HISTORY_DEPTH - 1) begin : g_tail
            assign w_feed = i_ctrl.height;
        end else begin : g_body
            assign w_feed = w_cell[g+1];
        end

        cos_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_ctrl.push),
            .i_data  (w_feed),
            .o_data  (w_cell[g])
        );
    end

    // Select the requested column; columns past the row read as zero
    assign w_col_ext  = cos_pkg::COL_EXT_W'(i_ctrl.column);
    assign w_in_range = (w_col_ext < cos_pkg::COL_EXT_W'(cos_pkg::HISTORY_DEPTH));
    assign w_idx      = w_col_ext[cos_pkg::HIST_IDX_W-1:0];

    always_comb begin
        if (w_in_range) begin
            o_rd_height = w_cell[w_idx];
        end else begin
            o_rd_height = '0;
        end
    end

endmodule

// File: hw/rtl/cos_out_queue.sv
`timescale 1ns / 1ps

module cos_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push0,
    input  logic               i_push1,
    input  cos_pkg::t_out_item i_data0,
    input  cos_pkg::t_out_item i_data1,
    output logic               o_room2,
    output logic               o_valid,
    input  logic               i_ready,
    output cos_pkg::t_out_item o_data
);

    cos_pkg::t_out_item             r_entry [cos_pkg::OQ_DEPTH];
    logic [cos_pkg::OQ_PTR_W-1:0]   r_wr_ptr;
    logic [cos_pkg::OQ_PTR_W-1:0]   r_rd_ptr;
    logic [cos_pkg::OQ_CNT_W-1:0]   r_count;
    logic [cos_pkg::OQ_PTR_W-1:0]   w_wr_ptr1;
    logic                           w_pop;
    logic [cos_pkg::OQ_CNT_W-1:0]   w_n_pushed;

    assign w_wr_ptr1  = r_wr_ptr + cos_pkg::OQ_PTR_W'(1);
    assign w_pop      = o_valid && i_ready;
    assign w_n_pushed = cos_pkg::OQ_CNT_W'(i_push0) + cos_pkg::OQ_CNT_W'(i_push1);

    // Store up to two results a cycle
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_entry[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_entry[w_wr_ptr1] <= i_data1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + w_n_pushed[cos_pkg::OQ_PTR_W-1:0];
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + cos_pkg::OQ_PTR_W'(1);
            end
            r_count <= r_count + w_n_pushed - cos_pkg::OQ_CNT_W'(w_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_room2 = (r_count <= cos_pkg::OQ_CNT_W'(cos_pkg::OQ_DEPTH - 2));

endmodule

// File: hw/rtl/channel_occupancy_scanner_unit.sv
`timescale 1ns / 1ps

// Channel occupancy scanner.
// Input channel (i_in_valid / o_in_ready / i_in_item): one request per cycle while ready, either a
// carrier-detect sample, a pause toggle, an exit to idle or a history column read.
// Samples arrive channel by channel in sweep order, SAMPLES per channel.
// Output channel (o_out_valid / i_out_ready / o_out_item): a count for every finished
// channel, a summary after the last channel of a sweep, and read data for column reads.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): full-scale bar height, always
// ready; write it only while the block is idle.
// Results: with the output queue empty, the first result is valid in the cycle after the
// request is accepted; a sweep summary is queued with its channel count, directly behind it.
// Throughput: one request per cycle. The limit is the four-entry output queue: a request
// is taken while it has two free entries, since a sweep end yields two results.
// Receiver stall: results collect in the queue and o_in_ready falls once fewer than two
// entries are free; it rises again as results are taken.
// Reset (synchronous, active low): idle, sweep at channel 0, counts and active channel
// cleared, full scale 55, and every history cell cleared in the same cycle.
// History: a row of HISTORY_DEPTH cells shifted on each sweep end, column 0 oldest.
module channel_occupancy_scanner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  cos_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cos_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cos_pkg::SCALE_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SCANNING,
        MODE_PAUSED
    } t_mode_e;

    t_mode_e                       r_mode,        n_mode;
    logic                          r_pause,       n_pause;
    logic [cos_pkg::CH_W-1:0]      r_sweep_ch,    n_sweep_ch;
    logic [cos_pkg::IDX_W-1:0]     r_sample_idx,  n_sample_idx;
    logic [cos_pkg::HITS_W-1:0]    r_ch_hits,     n_ch_hits;
    logic [cos_pkg::HITS_W-1:0]    r_best_hits,   n_best_hits;
    logic [cos_pkg::CH_W-1:0]      r_active_ch,   n_active_ch;
    logic [cos_pkg::SCALE_W-1:0]   r_full_scale;

    logic                          w_accept;
    logic                          w_count_en;
    logic [cos_pkg::HITS_W-1:0]    w_hits_new;
    logic [cos_pkg::IDX_W-1:0]     w_idx_inc;
    logic                          w_chan_done;
    logic                          w_sweep_done;
    logic                          w_beat;
    logic [cos_pkg::HITS_W-1:0]    w_best_new;
    logic [cos_pkg::CH_W-1:0]      w_active_new;
    logic [cos_pkg::PROD_W-1:0]    w_prod;
    logic [cos_pkg::PROD_W-1:0]    w_quot;
    logic [cos_pkg::HEIGHT_W-1:0]  w_height;
    logic [cos_pkg::HEIGHT_W-1:0]  w_rd_height;
    logic                          w_room2;
    logic                          w_push0;
    logic                          w_push1;
    cos_pkg::t_out_item            w_res0;
    cos_pkg::t_out_item            w_res1;
    cos_pkg::t_hist_ctrl           w_hist_ctrl;

    assign o_in_ready  = w_room2;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // Samples count unless paused; a sample taken in idle starts the scan and clears the pause
    assign w_count_en = (r_mode == MODE_IDLE) || !r_pause;

    // Channel counters
    always_comb begin
        if (i_in_item.carrier_seen && (r_ch_hits != cos_pkg::HITS_MAX)) begin
            w_hits_new = r_ch_hits + cos_pkg::HITS_W'(1);
        end else begin
            w_hits_new = r_ch_hits;
        end
    end

    assign w_idx_inc    = r_sample_idx + cos_pkg::IDX_W'(1);
    assign w_chan_done  = (w_idx_inc >= cos_pkg::IDX_W'(cos_pkg::SAMPLES));
    assign w_sweep_done = ((cos_pkg::IDX_W'(r_sweep_ch) + cos_pkg::IDX_W'(1))
                           >= cos_pkg::IDX_W'(cos_pkg::NUM_CHANNELS));

    // Best channel: first one with a strictly greater count wins
    assign w_beat       = (w_hits_new > r_best_hits);
    assign w_best_new   = w_beat ? w_hits_new : r_best_hits;
    assign w_active_new = w_beat ? r_sweep_ch : r_active_ch;

    // Bar height, truncated and clipped to the display range
    assign w_prod = cos_pkg::PROD_W'(w_best_new) * cos_pkg::PROD_W'(r_full_scale);
    assign w_quot = w_prod / cos_pkg::PROD_W'(cos_pkg::SAMPLES);

    always_comb begin
        if (w_quot > cos_pkg::PROD_W'(cos_pkg::HEIGHT_MAX)) begin
            w_height = cos_pkg::HEIGHT_MAX;
        end else begin
            w_height = w_quot[cos_pkg::HEIGHT_W-1:0];
        end
    end

    // Decode the request and form its results
    always_comb begin
        n_mode       = r_mode;
        n_pause      = r_pause;
        n_sweep_ch   = r_sweep_ch;
        n_sample_idx = r_sample_idx;
        n_ch_hits    = r_ch_hits;
        n_best_hits  = r_best_hits;
        n_active_ch  = r_active_ch;
        w_push0      = 1'b0;
        w_push1      = 1'b0;
        w_res0       = '0;
        w_res1       = '0;
        w_hist_ctrl.push   = 1'b0;
        w_hist_ctrl.height = w_height;
        w_hist_ctrl.column = i_in_item.column;

        if (w_accept) begin
            unique case (i_in_item.action)
                cos_pkg::ACT_PAUSE: begin
                    n_pause = !r_pause;
                    n_mode  = r_pause ? MODE_SCANNING : MODE_PAUSED;
                end
                cos_pkg::ACT_EXIT: begin
                    n_mode       = MODE_IDLE;
                    n_sweep_ch   = '0;
                    n_sample_idx = '0;
                    n_ch_hits    = '0;
                    n_best_hits  = '0;
                end
                cos_pkg::ACT_READ: begin
                    w_push0           = 1'b1;
                    w_res0.kind       = cos_pkg::KIND_HIST;
                    w_res0.bar_height = w_rd_height;
                    w_res0.is_last    = 1'b1;
                end
                cos_pkg::ACT_SAMPLE: begin
                    if (r_mode == MODE_IDLE) begin
                        n_mode  = MODE_SCANNING;
                        n_pause = 1'b0;
                    end
                    if (w_count_en) begin
                        if (!w_chan_done) begin
                            n_sample_idx = w_idx_inc;
                            n_ch_hits    = w_hits_new;
                        end else begin
                            n_sample_idx     = '0;
                            n_ch_hits        = '0;
                            w_push0          = 1'b1;
                            w_res0.kind      = cos_pkg::KIND_COUNT;
                            w_res0.channel   = r_sweep_ch;
                            w_res0.hit_count = w_hits_new;
                            w_res0.is_last   = !w_sweep_done;
                            if (!w_sweep_done) begin
                                n_sweep_ch  = r_sweep_ch + cos_pkg::CH_W'(1);
                                n_best_hits = w_best_new;
                                n_active_ch = w_active_new;
                            end else begin
                                n_sweep_ch        = '0;
                                n_best_hits       = '0;
                                n_active_ch       = w_active_new;
                                w_hist_ctrl.push  = 1'b1;
                                w_push1           = 1'b1;
                                w_res1.kind       = cos_pkg::KIND_SUMMARY;
                                w_res1.channel    = w_active_new;
                                w_res1.hit_count  = w_best_new;
                                w_res1.bar_height = w_height;
                                w_res1.is_last    = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Hold sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_pause      <= 1'b0;
            r_sweep_ch   <= '0;
            r_sample_idx <= '0;
            r_ch_hits    <= '0;
            r_best_hits  <= '0;
            r_active_ch  <= '0;
            r_full_scale <= cos_pkg::FULL_SCALE_RESET;
        end else begin
            r_mode       <= n_mode;
            r_pause      <= n_pause;
            r_sweep_ch   <= n_sweep_ch;
            r_sample_idx <= n_sample_idx;
            r_ch_hits    <= n_ch_hits;
            r_best_hits  <= n_best_hits;
            r_active_ch  <= n_active_ch;
            if (i_cfg_valid && o_cfg_ready) begin
                r_full_scale <= i_cfg_data;
            end
        end
    end

    cos_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_hist_ctrl),
        .o_rd_height (w_rd_height)
    );

    cos_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_push1 (w_push1),
        .i_data0 (w_res0),
        .i_data1 (w_res1),
        .o_room2 (w_room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_item)
    );

endmodule

// File: hw/rtl/cos_checker.sv
`timescale 1ns / 1ps

module cos_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  cos_pkg::t_out_item          o_out_item
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A sweep-ending channel count is directly followed by its summary
    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_out_item.kind == cos_pkg::KIND_COUNT)
            && !o_out_item.is_last
        |=> o_out_valid && (o_out_item.kind == cos_pkg::KIND_SUMMARY))
        else $error("summary missing after last channel count");

    // Summaries and read data always close their request
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.kind == cos_pkg::KIND_SUMMARY)
            || (o_out_item.kind == cos_pkg::KIND_HIST))
        |-> o_out_item.is_last)
        else $error("summary or read data without last flag");

    // Read data carries no channel or count
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == cos_pkg::KIND_HIST)
        |-> (o_out_item.channel == '0) && (o_out_item.hit_count == '0))
        else $error("read data with channel or count set");

endmodule

bind channel_occupancy_scanner_unit cos_checker u_cos_checker (.*);

// File: tb/channel_occupancy_scanner_unit_tb.sv
`timescale 1ns / 1ps

module channel_occupancy_scanner_unit_tb;
    import cos_pkg::*;

    localparam int PHASE_ITEMS      = 130;
    localparam int N_PHASES         = 6;
    localparam int SETTLE_CYCLES    = 8;
    localparam int QUIET_LIMIT      = 4000;
    localparam int PRESSURE_AT      = 60;
    localparam int PRESSURE_HOLD    = 400;
    localparam int MAX_PRINTED      = 50;

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_RUN  = 2'd1,
        SCAN_HELD = 2'd2
    } t_scan_mode;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SCALE_W-1:0]  i_cfg_data  = '0;

    // Requests waiting to be offered, and results owed by the block
    t_in_item  pending_requests [$];
    t_out_item scan_results_due [$];

    // Shadow of the scanner state
    t_scan_mode          mdl_mode;
    logic                mdl_paused;
    logic [CH_W-1:0]     mdl_chan;
    logic [IDX_W-1:0]    mdl_sample;
    logic [HITS_W-1:0]   mdl_hits;
    logic [HITS_W-1:0]   mdl_best;
    logic [CH_W-1:0]     mdl_active;
    logic [HEIGHT_W-1:0] mdl_history [HISTORY_DEPTH];
    logic [SCALE_W-1:0]  mdl_scale;

    int unsigned mismatch_count = 0;
    int unsigned requests_taken = 0;
    int unsigned results_taken  = 0;
    int unsigned send_wait      = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned run_cycles     = 0;
    int unsigned pressure_left  = 0;

    channel_occupancy_scanner_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got_v, want_v);
        end
        mismatch_count++;
    endtask

    function automatic void clear_scan_model();
        mdl_mode    = SCAN_IDLE;
        mdl_paused  = 1'b0;
        mdl_chan    = '0;
        mdl_sample  = '0;
        mdl_hits    = '0;
        mdl_best    = '0;
        mdl_active  = '0;
        mdl_scale   = FULL_SCALE_RESET;
        for (int k = 0; k < HISTORY_DEPTH; k++) mdl_history[k] = '0;
    endfunction

    // Advance the shadow state by one request and queue the results it owes
    function automatic void predict_request(t_in_item req);
        t_out_item   r;
        int unsigned height;
        bit          sweep_end;
        case (req.action)
            ACT_PAUSE: begin
                mdl_paused = ~mdl_paused;
                mdl_mode   = mdl_paused ? SCAN_HELD : SCAN_RUN;
            end
            ACT_EXIT: begin
                mdl_mode   = SCAN_IDLE;
                mdl_chan   = '0;
                mdl_sample = '0;
                mdl_hits   = '0;
                mdl_best   = '0;
            end
            ACT_READ: begin
                r            = '0;
                r.kind       = KIND_HIST;
                r.bar_height = (int'(req.column) < HISTORY_DEPTH) ? mdl_history[req.column] : '0;
                r.is_last    = 1'b1;
                scan_results_due.push_back(r);
            end
            default: begin
                // A sample from idle starts the scan and clears the pause flag
                if (mdl_mode == SCAN_IDLE) begin
                    mdl_mode   = SCAN_RUN;
                    mdl_paused = 1'b0;
                end
                if (mdl_mode == SCAN_RUN && !mdl_paused) begin
                    if (req.carrier_seen && mdl_hits != HITS_MAX) mdl_hits = mdl_hits + 1'b1;
                    mdl_sample = mdl_sample + 1'b1;
                    if (int'(mdl_sample) >= SAMPLES) begin
                        sweep_end = (int'(mdl_chan) + 1 >= NUM_CHANNELS);
                        // First channel with the strictly greatest count wins
                        if (mdl_hits > mdl_best) begin
                            mdl_best   = mdl_hits;
                            mdl_active = mdl_chan;
                        end
                        r           = '0;
                        r.kind      = KIND_COUNT;
                        r.channel   = mdl_chan;
                        r.hit_count = mdl_hits;
                        r.is_last   = !sweep_end;
                        scan_results_due.push_back(r);
                        mdl_sample = '0;
                        mdl_hits   = '0;
                        if (!sweep_end) begin
                            mdl_chan = mdl_chan + 1'b1;
                        end else begin
                            height = (int'(mdl_best) * int'(mdl_scale)) / SAMPLES;
                            if (height > int'(HEIGHT_MAX)) height = HEIGHT_MAX;
                            for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
                                mdl_history[k] = mdl_history[k + 1];
                            end
                            mdl_history[HISTORY_DEPTH - 1] = HEIGHT_W'(height);
                            r            = '0;
                            r.kind       = KIND_SUMMARY;
                            r.channel    = mdl_active;
                            r.hit_count  = mdl_best;
                            r.bar_height = HEIGHT_W'(height);
                            r.is_last    = 1'b1;
                            scan_results_due.push_back(r);
                            mdl_chan = '0;
                            mdl_best = '0;
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic t_in_item make_req(t_action act, logic seen, logic [COL_W-1:0] col);
        t_in_item req;
        req.action       = act;
        req.carrier_seen = seen;
        req.column       = col;
        return req;
    endfunction

    // Queue a run of samples with reads, pauses and the odd exit mixed in
    task automatic queue_burst(int n_items);
        int   left;
        int   roll;
        int   k;
        int   dens;
        logic seen;
        left = n_items;
        dens = $urandom_range(0, SAMPLES);
        while (left > 0) begin
            roll = $urandom_range(0, 255);
            if (roll < 8) begin
                pending_requests.push_back(make_req(ACT_READ, 1'($urandom_range(0, 1)),
                                                    COL_W'($urandom_range(0, 127))));
                left--;
            end else if (roll < 10) begin
                // Pause, a few samples (dropped unless the pause flag was left set), resume
                k = $urandom_range(1, 5);
                pending_requests.push_back(make_req(ACT_PAUSE, 1'($urandom_range(0, 1)),
                                                    COL_W'($urandom_range(0, 127))));
                repeat (k) begin
                    pending_requests.push_back(make_req(ACT_SAMPLE, 1'($urandom_range(0, 1)),
                                                        COL_W'($urandom_range(0, 127))));
                end
                pending_requests.push_back(make_req(ACT_PAUSE, 1'($urandom_range(0, 1)),
                                                    COL_W'($urandom_range(0, 127))));
                left = left - k - 2;
            end else if (roll == 10) begin
                // Break the sweep off, sometimes with the pause flag left set
                if ($urandom_range(0, 1)) begin
                    pending_requests.push_back(make_req(ACT_PAUSE, 1'b0,
                                                        COL_W'($urandom_range(0, 127))));
                    left--;
                end
                pending_requests.push_back(make_req(ACT_EXIT, 1'($urandom_range(0, 1)),
                                                    COL_W'($urandom_range(0, 127))));
                left--;
            end else begin
                seen = ($urandom_range(0, SAMPLES - 1) < dens);
                pending_requests.push_back(make_req(ACT_SAMPLE, seen,
                                                    COL_W'($urandom_range(0, 127))));
                left--;
                if ($urandom_range(0, SAMPLES - 1) == 0) dens = $urandom_range(0, SAMPLES);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || i_in_valid || scan_results_due.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_full_scale(logic [SCALE_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_scale = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Offer requests from the pending queue with random gaps between them
    always @(posedge i_clk) begin
        int unsigned gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait  <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                predict_request(i_in_item);
                requests_taken <= requests_taken + 1;
                gap = requests_taken[9] ? 0 : $urandom_range(0, 7);
            end else begin
                gap = send_wait;
            end
            if (gap == 0 && pending_requests.size() > 0) begin
                i_in_item  <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
                send_wait  <= 0;
            end else begin
                i_in_valid <= 1'b0;
                send_wait  <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // Hold the receiver off once for long enough that the block backs up its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_cycles    <= 0;
            pressure_left <= 0;
        end else begin
            run_cycles <= run_cycles + 1;
            if (run_cycles == PRESSURE_AT) begin
                pressure_left <= PRESSURE_HOLD;
            end else if (pressure_left > 0) begin
                pressure_left <= pressure_left - 1;
            end
        end
    end

    // Take results, check them in order, and stall the output now and then
    always @(posedge i_clk) begin
        int unsigned stall;
        t_out_item   want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (scan_results_due.size() == 0) begin
                    report_mismatch("result with none expected, kind", o_out_item.kind, 0);
                end else begin
                    want = scan_results_due.pop_front();
                    if (o_out_item.kind != want.kind)
                        report_mismatch("kind", o_out_item.kind, want.kind);
                    if (o_out_item.channel != want.channel)
                        report_mismatch("channel", o_out_item.channel, want.channel);
                    if (o_out_item.hit_count != want.hit_count)
                        report_mismatch("hit_count", o_out_item.hit_count, want.hit_count);
                    if (o_out_item.bar_height != want.bar_height)
                        report_mismatch("bar_height", o_out_item.bar_height, want.bar_height);
                    if (o_out_item.is_last != want.is_last)
                        report_mismatch("is_last", o_out_item.is_last, want.is_last);
                end
                results_taken <= results_taken + 1;
                stall = results_taken[5] ? 0 : $urandom_range(0, 7);
            end else begin
                stall = hold_left;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                hold_left   <= stall - 1;
            end else begin
                i_out_ready <= (pressure_left == 0);
                hold_left   <= 0;
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("channel_occupancy_scanner_unit_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [SCALE_W-1:0] scale_plan [N_PHASES];
        scale_plan = '{FULL_SCALE_RESET, 6'd63, 6'd0, 6'd1, 6'd0, 6'd0};
        scale_plan[4] = $urandom_range(1, 63);
        scale_plan[5] = $urandom_range(0, 63);
        clear_scan_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads of a cleared history, pause from idle and paused, exit from scanning and paused
        pending_requests.push_back(make_req(ACT_READ, 1'b0, 7'd0));
        pending_requests.push_back(make_req(ACT_READ, 1'b1, 7'd127));
        pending_requests.push_back(make_req(ACT_PAUSE, 1'b0, 7'd0));
        pending_requests.push_back(make_req(ACT_SAMPLE, 1'b1, 7'd127));
        pending_requests.push_back(make_req(ACT_PAUSE, 1'b1, 7'd85));
        pending_requests.push_back(make_req(ACT_SAMPLE, 1'b1, 7'd42));
        pending_requests.push_back(make_req(ACT_EXIT, 1'b0, 7'd0));
        pending_requests.push_back(make_req(ACT_PAUSE, 1'b0, 7'd1));
        pending_requests.push_back(make_req(ACT_EXIT, 1'b1, 7'd127));
        pending_requests.push_back(make_req(ACT_SAMPLE, 1'b1, 7'd0));
        pending_requests.push_back(make_req(ACT_SAMPLE, 1'b0, 7'd127));
        pending_requests.push_back(make_req(ACT_READ, 1'b1, 7'd64));
        // Finish channel 0 with the remaining samples all hit
        repeat (SAMPLES - 2) pending_requests.push_back(make_req(ACT_SAMPLE, 1'b1, 7'd0));

        // Random traffic under several full-scale settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) write_full_scale(scale_plan[ph]);
            queue_burst(PHASE_ITEMS);
            wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (scan_results_due.size() != 0) begin
            report_mismatch("results never delivered", scan_results_due.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("channel_occupancy_scanner_unit_tb: PASS");
        end else begin
            $display("channel_occupancy_scanner_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
